// ----- hw/rtl/u8fb_pkg.sv -----
// ----------------------------------------------------------------------------
// u8fb_pkg - shared types and tables for the UTF-8 to font byte transcoder
// Holds the classified byte token, queue sizing and the Latin-1 glyph ROM.
// ----------------------------------------------------------------------------
package u8fb_pkg;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one classified input byte
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic       is_cont;    // 10xxxxxx
      logic       is_lead2;   // 110xxxxx
      logic       is_lead3;   // 1110xxxx
      logic       is_lead4;   // 11110xxx
      logic       is_print;   // ASCII 32..126
   } token_type;

   // open multi-byte sequence, one-hot
   typedef enum logic [3:0] {
      PEND_NONE  = 4'b0001,
      PEND_TWO   = 4'b0010,
      PEND_THREE = 4'b0100,
      PEND_FOUR  = 4'b1000
   } pend_type;

   // code point U+00A0..U+00FF (offset from 0xA0) to CP437, zero means no glyph
   function automatic logic [7:0] glyph_lookup(input logic [6:0] idx);
      logic [7:0] g;
      case (idx)
         7'd0:  g = 8'h20;
         7'd1:  g = 8'hAD;
         7'd2:  g = 8'h9B;
         7'd3:  g = 8'h9C;
         7'd5:  g = 8'h9D;
         7'd10: g = 8'hA6;
         7'd11: g = 8'hAE;
         7'd12: g = 8'hAA;
         7'd16: g = 8'hF8;
         7'd17: g = 8'hF1;
         7'd18: g = 8'hFD;
         7'd21: g = 8'hE6;
         7'd23: g = 8'hFA;
         7'd26: g = 8'hA7;
         7'd27: g = 8'hAF;
         7'd28: g = 8'hAC;
         7'd29: g = 8'hAB;
         7'd31: g = 8'hA8;
         7'd36: g = 8'h8E;
         7'd37: g = 8'h8F;
         7'd38: g = 8'h92;
         7'd39: g = 8'h80;
         7'd41: g = 8'h90;
         7'd49: g = 8'hA5;
         7'd54: g = 8'h99;
         7'd60: g = 8'h9A;
         7'd63: g = 8'hE1;
         7'd64: g = 8'h85;
         7'd65: g = 8'hA0;
         7'd66: g = 8'h83;
         7'd68: g = 8'h84;
         7'd69: g = 8'h86;
         7'd70: g = 8'h91;
         7'd71: g = 8'h87;
         7'd72: g = 8'h8A;
         7'd73: g = 8'h82;
         7'd74: g = 8'h88;
         7'd75: g = 8'h89;
         7'd76: g = 8'h8D;
         7'd77: g = 8'hA1;
         7'd78: g = 8'h8C;
         7'd79: g = 8'h8B;
         7'd81: g = 8'hA4;
         7'd82: g = 8'h95;
         7'd83: g = 8'hA2;
         7'd84: g = 8'h93;
         7'd86: g = 8'h94;
         7'd87: g = 8'hF6;
         7'd89: g = 8'h97;
         7'd90: g = 8'hA3;
         7'd91: g = 8'h96;
         7'd92: g = 8'h81;
         7'd95: g = 8'h98;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

endpackage

// ----- hw/rtl/utf8_to_font_byte_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_font_byte_transcoder - UTF-8 byte stream to single-byte font codes
// A req beat that yields a result is registered in the queue, then in the output reg.
// Throughput: one byte per cycle while rsp is not stalled; decode and ROM lookup are combinational.
// A 4-entry queue lets the input keep accepting while rsp is stalled, until it fills.
// Reset: synchronous, clears queue, sequence state, glyph count and rsp valid.
// ----------------------------------------------------------------------------
module utf8_to_font_byte_transcoder
   import u8fb_pkg::*;
#(
   parameter int MAX_TEXT = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] font_byte, [13:8] glyph_count
   output logic        rsp_tlast,   // end_of_text
   output logic        rsp_tuser    // glyph_valid
);

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_not_empty;
   token_type push_token;
   token_type head_token;

   // classify and accept
   u8fb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_token    (push_token)
   );

   // decoupling queue
   u8fb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (push_token),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .pop        (q_pop),
      .head_token (head_token)
   );

   // decode and emit
   u8fb_back #(
      .MAX_TEXT (MAX_TEXT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (head_token),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ----- hw/rtl/u8fb_front.sv -----
// ----------------------------------------------------------------------------
// u8fb_front - input side: accepts byte beats and classifies them
// Tags each byte by its UTF-8 role and pushes the token into the queue.
// ----------------------------------------------------------------------------
module u8fb_front
   import u8fb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // last_byte
   input  logic       q_full,
   output logic       q_push,
   output token_type  q_token
);

   logic [7:0] b;

   // accept whenever the queue has room
   assign req_tready = ~q_full;
   assign q_push     = req_tvalid & ~q_full;
   assign b          = req_tdata;

   // byte classification
   always_comb begin
      q_token.text_byte = b;
      q_token.last_byte = req_tlast;
      q_token.is_cont   = (b[7:6] == 2'b10);
      q_token.is_lead2  = (b[7:5] == 3'b110);
      q_token.is_lead3  = (b[7:4] == 4'b1110);
      q_token.is_lead4  = (b[7:3] == 5'b11110);
      q_token.is_print  = (b >= 8'd32) && (b <= 8'd126);
   end

   // push never lands on a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> ~q_full) else $error("push into full queue");

endmodule

// ----- hw/rtl/u8fb_queue.sv -----
// ----------------------------------------------------------------------------
// u8fb_queue - short token queue between front and back
// Register-based FIFO; the head token is presented combinationally.
// ----------------------------------------------------------------------------
module u8fb_queue
   import u8fb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      full,
   output logic      not_empty,
   input  logic      pop,
   output token_type head_token
);

   token_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_token = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");

endmodule

// ----- hw/rtl/u8fb_back.sv -----
// ----------------------------------------------------------------------------
// u8fb_back - decode side: UTF-8 sequence tracker, glyph ROM and output beat
// Pops one token per cycle when the output register can take a result.
// ----------------------------------------------------------------------------
module u8fb_back
   import u8fb_pkg::*;
#(
   parameter int MAX_TEXT = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  token_type   q_head,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [7:0] font_byte, [13:8] glyph_count, [15:14] zero
   output logic        rsp_tlast,  // end_of_text
   output logic        rsp_tuser   // glyph_valid
);

   localparam int                CNT_W = $clog2(MAX_TEXT);
   localparam logic [CNT_W-1:0]  CAP   = CNT_W'(MAX_TEXT - 1);

   pend_type          pend_ff, pend_in;
   logic [1:0]        need_ff, need_in;
   logic [4:0]        payload_ff, payload_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        font_ff, font_in;
   logic [5:0]        shown_ff, shown_in;
   logic              eot_ff, eot_in;
   logic              gv_ff, gv_in;

   logic              back_ready;
   logic [7:0]        b;
   logic [7:0]        cp_low;
   logic [6:0]        rom_idx;
   logic              cp_in_range;
   logic [7:0]        glyph;
   logic              consumed;
   logic [8:0]        cnt_ext;

   assign back_ready = ~rsp_valid_ff | rsp_tready;
   assign q_pop      = q_not_empty & back_ready;
   assign b          = q_head.text_byte;

   // two-byte point, low 8 bits, and its ROM index
   assign cp_low      = {payload_ff[1:0], b[5:0]};
   assign cp_in_range = (payload_ff == 5'd3) || ((payload_ff == 5'd2) && b[5]);
   assign rom_idx     = 7'(cp_low - 8'hA0);

   // sequence tracking and glyph selection
   always_comb begin
      pend_in    = pend_ff;
      need_in    = need_ff;
      payload_in = payload_ff;
      count_in   = count_ff;
      glyph      = 8'h00;
      consumed   = 1'b0;
      if (count_ff < CAP) begin
         if (pend_ff != PEND_NONE) begin
            if (q_head.is_cont) begin
               consumed = 1'b1;
               if (pend_ff == PEND_TWO) begin
                  glyph      = cp_in_range ? glyph_lookup(rom_idx) : 8'h00;
                  pend_in    = PEND_NONE;
                  need_in    = 2'd0;
                  payload_in = 5'd0;
               end else begin
                  need_in = need_ff - 2'd1;
                  if (need_ff == 2'd1) begin
                     pend_in    = PEND_NONE;
                     payload_in = 5'd0;
                  end
               end
            end else begin
               // broken sequence: drop it, reprocess this byte
               pend_in    = PEND_NONE;
               need_in    = 2'd0;
               payload_in = 5'd0;
            end
         end
         if (!consumed) begin
            if (q_head.is_print) begin
               glyph = b;
            end else if (q_head.is_lead2) begin
               pend_in    = PEND_TWO;
               need_in    = 2'd1;
               payload_in = b[4:0];
            end else if (q_head.is_lead3) begin
               pend_in    = PEND_THREE;
               need_in    = 2'd2;
               payload_in = 5'd0;
            end else if (q_head.is_lead4) begin
               pend_in    = PEND_FOUR;
               need_in    = 2'd3;
               payload_in = 5'd0;
            end
         end
         if (glyph != 8'h00) begin
            count_in = CNT_W'(count_ff + 1'b1);
         end
      end
      // end of string clears the sequence state and the glyph count
      if (q_head.last_byte) begin
         pend_in    = PEND_NONE;
         need_in    = 2'd0;
         payload_in = 5'd0;
         count_in   = '0;
      end
   end

   // count shown in the beat, saturating at 63
   always_comb begin
      cnt_ext  = 9'(count_ff) + ((glyph != 8'h00) ? 9'd1 : 9'd0);
      shown_in = (cnt_ext > 9'd63) ? 6'd63 : cnt_ext[5:0];
   end

   // output register load
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      font_in      = font_ff;
      eot_in       = eot_ff;
      gv_in        = gv_ff;
      if (q_pop && ((glyph != 8'h00) || q_head.last_byte)) begin
         rsp_valid_in = 1'b1;
         font_in      = glyph;
         eot_in       = q_head.last_byte;
         gv_in        = (glyph != 8'h00);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= PEND_NONE;
         need_ff      <= 2'd0;
         payload_ff   <= 5'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            pend_ff    <= pend_in;
            need_ff    <= need_in;
            payload_ff <= payload_in;
            count_ff   <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      font_ff <= font_in;
      eot_ff  <= eot_in;
      gv_ff   <= gv_in;
      if (q_pop) begin
         shown_ff <= shown_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, shown_ff, font_ff};
   assign rsp_tlast  = eot_ff;
   assign rsp_tuser  = gv_ff;

   a_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP) else $error("glyph count past cap");
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_head.last_byte |=> (count_ff == '0) && (pend_ff == PEND_NONE))
      else $error("state not cleared after last byte");
   a_glyph_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && gv_ff |-> font_ff != 8'h00) else $error("empty glyph flagged");
   a_beat_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> gv_ff || eot_ff) else $error("beat without glyph or end");

endmodule
